@@ rtl/form_urlencoded_pair_parser_defines.svh @@
// Assertion macros used by the parser datapath.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef FORM_URLENCODED_PAIR_PARSER_DEFINES_SVH
`define FORM_URLENCODED_PAIR_PARSER_DEFINES_SVH

// Same-cycle implication.
`define FUP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FUP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fup_pkg.sv @@
`default_nettype none
package fup_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int VALUE_BYTES = 32;
  localparam int KEY_AW      = $clog2(KEY_BYTES);
  localparam int VAL_AW      = $clog2(VALUE_BYTES);

  localparam logic [7:0] MAX_PAIRS_RST = 8'd8;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VAL      = 2'd1,
    KIND_PAIR_END = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_MID_PAIR = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_KEY_RD  = 6'b000010,
    S_KEY_OUT = 6'b000100,
    S_VAL     = 6'b001000,
    S_PEND    = 6'b010000,
    S_STAT    = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;
    logic  key_rd;
    logic  val_run;
    logic  val_step;
    logic  emit;
    kind_t emit_kind;
    logic  pair_done;
    logic  body_clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fire;
    logic eob_in;
    logic key_empty;
    logic key_last;
    logic val_rdy;
    logic val_zero;
    logic val_done;
    logic can_load;
    logic eob_pend;
  } sts_t;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/form_urlencoded_pair_parser.sv @@
`default_nettype none
// A byte that completes a pair stalls input and shows its key bytes first; when the key is
// empty but the value is not, the decode window fills before the first value word. A byte that
// only ends the body shows just its status word. Plain bytes are taken without a stall.
// Drain: each key byte passes S_KEY_RD then S_KEY_OUT, each value word is a plain byte or an
// escape from the window, then the value is left for the pair end word and any status word.
// Reset: synchronous, active low; clears all control state and sets max_pairs to 8.
module form_urlencoded_pair_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_body_byte,
  input  wire logic       in_end_of_body,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data,
  output logic [7:0]      out_pair_index,
  output logic [1:0]      out_status,
  output logic            out_last_result
);
  import fup_pkg::*;

  // The controller sequences each accepted byte: it takes a byte only when
  // idle, then walks the key buffer, the value decode window, the pair end
  // word and the body status word. The datapath holds the buffers, counters,
  // the decode window and the output register. Because the output register
  // sits between the drain and the result channel, a new byte can be taken
  // while the last word of the previous one is still waiting downstream.
  cmd_t cmd;
  sts_t sts;

  fup_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Value bytes are decoded on the way out: percent escapes become one byte,
  // plus signs become spaces, and the drain stops at the first zero byte.
  fup_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_body_byte    (in_body_byte),
    .in_end_of_body  (in_end_of_body),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_pair_index  (out_pair_index),
    .out_status      (out_status),
    .out_last_result (out_last_result),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire

@@ rtl/fup_ctrl.sv @@
`default_nettype none
module fup_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  output fup_pkg::cmd_t     cmd,
  input  wire fup_pkg::sts_t sts
);
  import fup_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    cmd.accept  = accept;
    cmd.val_run = (state_r == S_VAL);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.fire) begin
            state_nxt = sts.key_empty ? S_VAL : S_KEY_RD;
          end else if (sts.eob_in) begin
            state_nxt = S_STAT;
          end
        end
      end
      S_KEY_RD: begin
        cmd.key_rd = 1'b1;
        state_nxt  = S_KEY_OUT;
      end
      S_KEY_OUT: begin
        if (sts.can_load) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_KEY;
          state_nxt     = sts.key_last ? S_VAL : S_KEY_RD;
        end
      end
      S_VAL: begin
        if (sts.val_done) begin
          state_nxt = S_PEND;
        end else if (sts.val_rdy) begin
          if (sts.val_zero) begin
            state_nxt = S_PEND;
          end else if (sts.can_load) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_VAL;
            cmd.val_step  = 1'b1;
          end
        end
      end
      S_PEND: begin
        if (sts.can_load) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_PAIR_END;
          cmd.pair_done = 1'b1;
          state_nxt     = sts.eob_pend ? S_STAT : S_IDLE;
        end
      end
      S_STAT: begin
        if (sts.can_load) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_STATUS;
          cmd.body_clear = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fup_datapath.sv @@
`default_nettype none
`include "form_urlencoded_pair_parser_defines.svh"
module fup_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_wr_data,
  input  wire logic [7:0]    in_body_byte,
  input  wire logic          in_end_of_body,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_data,
  output logic [7:0]         out_pair_index,
  output logic [1:0]         out_status,
  output logic               out_last_result,
  input  wire fup_pkg::cmd_t cmd,
  output fup_pkg::sts_t      sts
);
  import fup_pkg::*;

  // Body parse state.
  logic [7:0]        max_pairs_r, max_pairs_nxt;
  logic              value_phase_r, value_phase_nxt;
  logic              err_r, err_nxt;
  logic [KEY_AW-1:0] key_count_r, key_count_nxt;
  logic [VAL_AW-1:0] value_count_r, value_count_nxt;
  logic [7:0]        pairs_done_r, pairs_done_nxt;
  logic              eob_r, eob_nxt;

  // Drain state.
  logic [KEY_AW-1:0] kptr_r, kptr_nxt;
  logic [VAL_AW-1:0] fptr_r, fptr_nxt;
  logic              inflight_r, inflight_nxt;
  logic [1:0]        wcnt_r, wcnt_nxt;
  logic [7:0]        win_r [3];
  logic [7:0]        win_nxt [3];
  logic [7:0]        key_rd_r;
  logic [7:0]        val_rd_r;

  logic [7:0] key_mem [KEY_BYTES];
  logic [7:0] val_mem [VALUE_BYTES];

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  kind_t      out_kind_r;
  logic [7:0] out_data_r;
  logic [7:0] out_pair_index_r;
  status_t    out_status_r;
  logic       out_last_r;

  logic key_wr, val_wr, finish, err_set, to_value, over_limit, fire;
  logic key_wr_en, val_wr_en;

  logic       all_fetched, esc, issue, can_load;
  logic [4:0] h1, h2;
  logic [7:0] dec_byte;
  logic [1:0] take, wcnt_after;
  status_t    body_status;

  // Classify the incoming byte.
  always_comb begin
    key_wr   = 1'b0;
    val_wr   = 1'b0;
    finish   = 1'b0;
    err_set  = 1'b0;
    to_value = 1'b0;
    if (!err_r) begin
      if (!value_phase_r) begin
        if (in_body_byte == CH_EQ) begin
          to_value = 1'b1;
        end else if (in_body_byte == CH_AMP) begin
          err_set = 1'b1;
        end else if (key_count_r < KEY_AW'(KEY_BYTES - 1)) begin
          key_wr = 1'b1;
        end else begin
          err_set = 1'b1;
        end
      end else begin
        if (in_body_byte == CH_AMP) begin
          finish = 1'b1;
        end else if (in_body_byte == CH_EQ) begin
          err_set = 1'b1;
        end else if (value_count_r < VAL_AW'(VALUE_BYTES - 1)) begin
          val_wr = 1'b1;
          finish = in_end_of_body;
        end else begin
          err_set = 1'b1;
        end
      end
    end
    over_limit = (pairs_done_r >= max_pairs_r);
    fire       = finish && !over_limit;
  end

  assign key_wr_en = cmd.accept && key_wr;
  assign val_wr_en = cmd.accept && val_wr;

  // Value decode window: up to three raw bytes ahead of the output.
  assign h1          = hex_decode(win_r[1]);
  assign h2          = hex_decode(win_r[2]);
  assign all_fetched = (fptr_r == value_count_r) && !inflight_r;
  assign esc         = (win_r[0] == CH_PCT) && (wcnt_r == 2'd3) && h1[4] && h2[4];
  assign take        = esc ? 2'd3 : 2'd1;
  assign wcnt_after  = cmd.val_step ? (wcnt_r - take) : wcnt_r;
  assign issue       = cmd.val_run && (fptr_r != value_count_r) &&
                       (({1'b0, wcnt_after} + {2'b00, inflight_r}) < 3'd3);
  assign can_load    = !out_valid_r || !out_stall;

  always_comb begin
    if (esc) begin
      dec_byte = {h1[3:0], h2[3:0]};
    end else if (win_r[0] == CH_PLUS) begin
      dec_byte = CH_SPACE;
    end else begin
      dec_byte = win_r[0];
    end
  end

  always_comb begin
    if (err_r) begin
      body_status = ST_ERROR;
    end else if (!value_phase_r && (key_count_r == '0)) begin
      body_status = ST_COMPLETE;
    end else begin
      body_status = ST_MID_PAIR;
    end
  end

  always_comb begin
    sts.fire      = fire;
    sts.eob_in    = in_end_of_body;
    sts.key_empty = (key_count_r == '0);
    sts.key_last  = (kptr_r == key_count_r);
    sts.val_rdy   = (wcnt_r != 2'd0) &&
                    ((win_r[0] != CH_PCT) || (wcnt_r == 2'd3) || all_fetched);
    sts.val_zero  = (dec_byte == 8'd0);
    sts.val_done  = (wcnt_r == 2'd0) && all_fetched;
    sts.can_load  = can_load;
    sts.eob_pend  = eob_r;
  end

  // Next-state logic for parse and drain registers.
  always_comb begin
    max_pairs_nxt   = max_pairs_r;
    value_phase_nxt = value_phase_r;
    err_nxt         = err_r;
    key_count_nxt   = key_count_r;
    value_count_nxt = value_count_r;
    pairs_done_nxt  = pairs_done_r;
    eob_nxt         = eob_r;
    kptr_nxt        = kptr_r;
    fptr_nxt        = fptr_r;
    inflight_nxt    = issue;
    win_nxt         = win_r;
    wcnt_nxt        = wcnt_after;

    if (cfg_wr_en) begin
      max_pairs_nxt = cfg_wr_data;
    end

    if (cmd.val_step && (take == 2'd1)) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
    end
    if (inflight_r) begin
      win_nxt[wcnt_after] = val_rd_r;
      wcnt_nxt            = wcnt_after + 2'd1;
    end
    if (issue) begin
      fptr_nxt = fptr_r + VAL_AW'(1);
    end
    if (cmd.key_rd) begin
      kptr_nxt = kptr_r + KEY_AW'(1);
    end

    if (cmd.accept) begin
      if (key_wr) begin
        key_count_nxt = key_count_r + KEY_AW'(1);
      end
      if (val_wr) begin
        value_count_nxt = value_count_r + VAL_AW'(1);
      end
      if (to_value) begin
        value_phase_nxt = 1'b1;
      end
      if (err_set || (finish && over_limit)) begin
        err_nxt = 1'b1;
      end
      eob_nxt      = in_end_of_body;
      kptr_nxt     = '0;
      fptr_nxt     = '0;
      inflight_nxt = 1'b0;
      wcnt_nxt     = 2'd0;
    end

    if (cmd.pair_done) begin
      pairs_done_nxt  = pairs_done_r + 8'd1;
      key_count_nxt   = '0;
      value_count_nxt = '0;
      value_phase_nxt = 1'b0;
    end

    if (cmd.body_clear) begin
      pairs_done_nxt  = 8'd0;
      key_count_nxt   = '0;
      value_count_nxt = '0;
      value_phase_nxt = 1'b0;
      err_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pairs_r   <= MAX_PAIRS_RST;
      value_phase_r <= 1'b0;
      err_r         <= 1'b0;
      key_count_r   <= '0;
      value_count_r <= '0;
      pairs_done_r  <= 8'd0;
      eob_r         <= 1'b0;
      kptr_r        <= '0;
      fptr_r        <= '0;
      inflight_r    <= 1'b0;
      wcnt_r        <= 2'd0;
    end else begin
      max_pairs_r   <= max_pairs_nxt;
      value_phase_r <= value_phase_nxt;
      err_r         <= err_nxt;
      key_count_r   <= key_count_nxt;
      value_count_r <= value_count_nxt;
      pairs_done_r  <= pairs_done_nxt;
      eob_r         <= eob_nxt;
      kptr_r        <= kptr_nxt;
      fptr_r        <= fptr_nxt;
      inflight_r    <= inflight_nxt;
      wcnt_r        <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // Key and value buffers, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[key_count_r] <= in_body_byte;
    end
    if (cmd.key_rd) begin
      key_rd_r <= key_mem[kptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (val_wr_en) begin
      val_mem[value_count_r] <= in_body_byte;
    end
    if (issue) begin
      val_rd_r <= val_mem[fptr_r];
    end
  end

  // Output register.
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r       <= cmd.emit_kind;
      out_pair_index_r <= pairs_done_r;
      case (cmd.emit_kind)
        KIND_KEY: begin
          out_data_r   <= key_rd_r;
          out_status_r <= ST_COMPLETE;
          out_last_r   <= 1'b0;
        end
        KIND_VAL: begin
          out_data_r   <= dec_byte;
          out_status_r <= ST_COMPLETE;
          out_last_r   <= 1'b0;
        end
        KIND_PAIR_END: begin
          out_data_r   <= 8'd0;
          out_status_r <= ST_COMPLETE;
          out_last_r   <= !eob_r;
        end
        KIND_STATUS: begin
          out_data_r   <= 8'd0;
          out_status_r <= body_status;
          out_last_r   <= 1'b1;
        end
        default: begin
          out_data_r   <= 8'd0;
          out_status_r <= ST_COMPLETE;
          out_last_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_data        = out_data_r;
  assign out_pair_index  = out_pair_index_r;
  assign out_status      = out_status_r;
  assign out_last_result = out_last_r;

  `FUP_ASSERT_IMP(a_win_bound, 1'b1,
    ({1'b0, wcnt_r} + {2'b00, inflight_r}) <= 3'd3, "decode window overfilled")
  `FUP_ASSERT_IMP(a_fetch_bound, cmd.val_run, fptr_r <= value_count_r,
    "value fetch ran past the stored bytes")
  `FUP_ASSERT_IMP(a_emit_room, cmd.emit, can_load,
    "result loaded while output register is blocked")
  `FUP_ASSERT_NXT(a_pair_clear, cmd.pair_done,
    (key_count_r == '0) && (value_count_r == '0) && !value_phase_r,
    "pair buffers not cleared after pair end")

endmodule
`default_nettype wire
